FILE: rtl/core/vog_pkg.sv
// ----------------------------------------------------------------------------
// vog_pkg: shared types and constants of the voxel occupancy grid engine
// Command codes, the queued command record and the configuration record.
// ----------------------------------------------------------------------------
`default_nettype none

package vog_pkg;

    // Coordinates inside the grid in use never exceed 62 (6-bit extents).
    localparam int CW = 6;
    // Width of x*size_y+y and of the full linear address before trimming.
    localparam int RW = 12;
    localparam int FW = 18;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_QUERY  = 3'd2;
    localparam logic [2:0] OP_FILL   = 3'd3;
    localparam logic [2:0] OP_INFL   = 3'd4;
    localparam logic [2:0] OP_QINF   = 3'd5;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
    localparam logic [1:0] REG_RADIUS = 2'd3;

    typedef struct packed {
        logic [CW-1:0] ux;
        logic [CW-1:0] uy;
        logic [CW-1:0] uz;
        logic [3:0]    rad;
    } cfg_t;

    // One classified command. x/y/z carry the voxel, or the clamped low
    // corner of a box; hx/hy/hz the clamped high corner.
    typedef struct packed {
        logic [2:0]    op;
        logic          in_grid;
        logic          box_empty;
        logic          wv;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [CW-1:0] hx;
        logic [CW-1:0] hy;
        logic [CW-1:0] hz;
    } cmd_t;

    function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] v, input int dim);
        logic [CW-1:0] r;
        if (v == '0)
        begin
            r = CW'(1);
        end
        else if (32'(v) > dim)
        begin
            r = CW'(dim);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [9:0] sq5(input logic signed [4:0] v);
        logic signed [9:0] p;
        p = v * v;
        return 10'(p);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/voxel_occupancy_grid_engine.sv
// ----------------------------------------------------------------------------
// voxel_occupancy_grid_engine: 3-D occupancy grid with inflated copy
// Top level: configuration registers, intake front, queue and sequencer.
// ----------------------------------------------------------------------------
// Every request returns exactly one result, in order. A front stage checks
// bounds and clamps box corners as the request is accepted and drops it
// into a two-entry queue; a back sequencer then runs it against two
// one-bit-per-voxel memories of DIM_X*DIM_Y*DIM_Z entries, addressed
// (x*size_y+y)*size_z+z. Each voxel access passes through the address path
// (two multiplications on successive cycles) and one memory port.
// Clearing the map sweeps the whole memory. A box fill visits each voxel of
// the box in turn. Rebuilding the inflated map sweeps the inflated memory
// clear, scans every voxel of the grid in use, and for each occupied voxel
// walks the (2r+1)^3 cube and writes the points of the ball that lie inside
// the grid. After reset the block clears both maps, one entry per cycle,
// before it executes requests; up to two requests queue up meanwhile.
// The configuration port is always ready; sizes are clamped to 1..DIM and
// the radius to MAX_RADIUS as they are written, and must only be written
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_occupancy_grid_engine
    import vog_pkg::*;
#(
    parameter int DIM_X      = 32,
    parameter int DIM_Y      = 32,
    parameter int DIM_Z      = 32,
    parameter int MAX_RADIUS = 15
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        opcode,
    input  wire logic signed [7:0] ax,
    input  wire logic signed [7:0] ay,
    input  wire logic signed [7:0] az,
    input  wire logic signed [7:0] bx,
    input  wire logic signed [7:0] by_corner,
    input  wire logic signed [7:0] bz,
    input  wire logic              write_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   occupied_bit,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [5:0]        cfg_data
);

    cfg_t cfg_reg, cfg_next;
    cmd_t front_cmd, q_head;
    logic q_push, q_pop, q_full, q_empty;

    // Configuration registers hold the clamped values the datapath uses.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SIZE_X: cfg_next.ux = clamp_size(cfg_data, DIM_X);
                REG_SIZE_Y: cfg_next.uy = clamp_size(cfg_data, DIM_Y);
                REG_SIZE_Z: cfg_next.uz = clamp_size(cfg_data, DIM_Z);
                REG_RADIUS:
                begin
                    cfg_next.rad = (32'(cfg_data[3:0]) > MAX_RADIUS)
                                 ? 4'(MAX_RADIUS) : cfg_data[3:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ux  <= clamp_size(CW'(32), DIM_X);
            cfg_reg.uy  <= clamp_size(CW'(32), DIM_Y);
            cfg_reg.uz  <= clamp_size(CW'(32), DIM_Z);
            cfg_reg.rad <= 4'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vog_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .ax          (ax),
        .ay          (ay),
        .az          (az),
        .bx          (bx),
        .by_corner   (by_corner),
        .bz          (bz),
        .write_value (write_value),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (front_cmd)
    );

    vog_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (front_cmd),
        .pop   (q_pop),
        .dout  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    vog_back #(
        .DIM_X (DIM_X),
        .DIM_Y (DIM_Y),
        .DIM_Z (DIM_Z)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_cmd        (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .occupied_bit (occupied_bit)
    );

endmodule

`default_nettype wire

FILE: rtl/core/vog_queue.sv
// ----------------------------------------------------------------------------
// vog_queue: short command queue
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`default_nettype none

module vog_queue
    import vog_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t din,
    input  wire logic pop,
    output cmd_t      dout,
    output logic      full,
    output logic      empty
);

    cmd_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign empty = (count_reg == '0);

endmodule

`default_nettype wire

FILE: rtl/core/vog_front.sv
// ----------------------------------------------------------------------------
// vog_front: request intake and classification
// Checks bounds, clamps box corners and queues one command per request.
// ----------------------------------------------------------------------------
`default_nettype none

module vog_front
    import vog_pkg::*;
(
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        opcode,
    input  wire logic signed [7:0] ax,
    input  wire logic signed [7:0] ay,
    input  wire logic signed [7:0] az,
    input  wire logic signed [7:0] bx,
    input  wire logic signed [7:0] by_corner,
    input  wire logic signed [7:0] bz,
    input  wire logic              write_value,
    input  wire cfg_t              cfg,
    input  wire logic              q_full,
    output logic                   q_push,
    output cmd_t                   q_cmd
);

    logic signed [8:0] lo_x, lo_y, lo_z;
    logic signed [8:0] hi_x, hi_y, hi_z;
    logic signed [8:0] top_x, top_y, top_z;
    logic              is_fill;

    // Highest index in use along each axis.
    assign top_x = $signed({3'b000, cfg.ux}) - 9'sd1;
    assign top_y = $signed({3'b000, cfg.uy}) - 9'sd1;
    assign top_z = $signed({3'b000, cfg.uz}) - 9'sd1;

    assign lo_x = ax[7] ? 9'sd0 : 9'(ax);
    assign lo_y = ay[7] ? 9'sd0 : 9'(ay);
    assign lo_z = az[7] ? 9'sd0 : 9'(az);
    assign hi_x = (9'(bx) > top_x) ? top_x : 9'(bx);
    assign hi_y = (9'(by_corner) > top_y) ? top_y : 9'(by_corner);
    assign hi_z = (9'(bz) > top_z) ? top_z : 9'(bz);

    assign is_fill  = (opcode == OP_FILL);
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_cmd.op        = opcode;
        q_cmd.wv        = write_value;
        q_cmd.in_grid   = (9'(ax) >= 9'sd0) && (9'(ax) <= top_x)
                       && (9'(ay) >= 9'sd0) && (9'(ay) <= top_y)
                       && (9'(az) >= 9'sd0) && (9'(az) <= top_z);
        q_cmd.box_empty = (lo_x > hi_x) || (lo_y > hi_y) || (lo_z > hi_z);
        q_cmd.x         = is_fill ? CW'(lo_x) : CW'(ax);
        q_cmd.y         = is_fill ? CW'(lo_y) : CW'(ay);
        q_cmd.z         = is_fill ? CW'(lo_z) : CW'(az);
        q_cmd.hx        = CW'(hi_x);
        q_cmd.hy        = CW'(hi_y);
        q_cmd.hz        = CW'(hi_z);
    end

endmodule

`default_nettype wire

FILE: rtl/core/vog_back.sv
// ----------------------------------------------------------------------------
// vog_back: command sequencer and map storage
// Runs each queued command against the two bit maps and posts its result.
// ----------------------------------------------------------------------------
`default_nettype none

module vog_back
    import vog_pkg::*;
#(
    parameter int DIM_X = 32,
    parameter int DIM_Y = 32,
    parameter int DIM_Z = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic q_empty,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic      occupied_bit
);

    localparam int CELLS = DIM_X * DIM_Y * DIM_Z;
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [12:0] {
        ST_INIT = 13'b0000000000001,
        ST_IDLE = 13'b0000000000010,
        ST_CLR  = 13'b0000000000100,
        ST_ROW  = 13'b0000000001000,
        ST_ADDR = 13'b0000000010000,
        ST_ACC  = 13'b0000000100000,
        ST_RDW  = 13'b0000001000000,
        ST_STEP = 13'b0000010000000,
        ST_ICLR = 13'b0000100000000,
        ST_SRD  = 13'b0001000000000,
        ST_SCHK = 13'b0010000000000,
        ST_BALL = 13'b0100000000000,
        ST_DONE = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CW-1:0]     px_reg, py_reg, pz_reg, px_next, py_next, pz_next;
    logic [CW-1:0]     sx_reg, sy_reg, sz_reg, sx_next, sy_next, sz_next;
    logic signed [4:0] dx_reg, dy_reg, dz_reg, dx_next, dy_next, dz_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [RW-1:0]     row_reg;
    logic [AW-1:0]     addr_reg;
    logic              res_reg, res_next;
    logic              out_valid_reg, out_bit_reg;
    logic              out_load;

    logic              occ_mem [CELLS];
    logic              inf_mem [CELLS];
    logic              occ_rd_reg, inf_rd_reg;
    logic              occ_we, inf_we, occ_wd;
    logic [AW-1:0]     occ_wa, inf_wa, rd_addr;

    logic [FW-1:0]     addr_full;
    logic signed [4:0] n5;
    logic [9:0]        off_sq, rad_sq;
    logic signed [7:0] tx, ty, tz;
    logic              cand_ok, ball_last, scan_last, cnt_last;

    // Address path: two multiplications, one per cycle.
    assign addr_full = FW'(row_reg) * FW'(cfg.uz) + FW'(pz_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROW)
        begin
            row_reg <= RW'(px_reg) * RW'(cfg.uy) + RW'(py_reg);
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg <= AW'(addr_full);
        end
    end

    // Ball candidate around the scanned voxel.
    assign n5      = $signed({1'b0, cfg.rad});
    assign rad_sq  = 10'(cfg.rad) * 10'(cfg.rad);
    assign off_sq  = sq5(dx_reg) + sq5(dy_reg) + sq5(dz_reg);
    assign tx      = $signed({2'b00, sx_reg}) + 8'(dx_reg);
    assign ty      = $signed({2'b00, sy_reg}) + 8'(dy_reg);
    assign tz      = $signed({2'b00, sz_reg}) + 8'(dz_reg);
    assign cand_ok = (off_sq <= rad_sq)
                  && !tx[7] && (tx[6:0] < {1'b0, cfg.ux})
                  && !ty[7] && (ty[6:0] < {1'b0, cfg.uy})
                  && !tz[7] && (tz[6:0] < {1'b0, cfg.uz});
    assign ball_last = (dx_reg == n5) && (dy_reg == n5) && (dz_reg == n5);
    assign scan_last = (sx_reg == cfg.ux - 1'b1) && (sy_reg == cfg.uy - 1'b1)
                    && (sz_reg == cfg.uz - 1'b1);
    assign cnt_last  = (cnt_reg == AW'(CELLS - 1));

    // Map storage: one write and one registered read per map per cycle.
    assign rd_addr = (state_reg == ST_SRD) ? cnt_reg : addr_reg;

    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_wa] <= occ_wd;
        end
        occ_rd_reg <= occ_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (inf_we)
        begin
            inf_mem[inf_wa] <= 1'b0 | (state_reg == ST_ACC);
        end
        inf_rd_reg <= inf_mem[rd_addr];
    end

    always_comb
    begin
        occ_we = 1'b0;
        occ_wd = 1'b0;
        occ_wa = cnt_reg;
        inf_we = 1'b0;
        inf_wa = cnt_reg;
        case (state_reg)
            ST_INIT:
            begin
                occ_we = 1'b1;
                inf_we = 1'b1;
            end
            ST_CLR:
            begin
                occ_we = 1'b1;
            end
            ST_ICLR:
            begin
                inf_we = 1'b1;
            end
            ST_ACC:
            begin
                occ_wa = addr_reg;
                inf_wa = addr_reg;
                occ_we = (cmd_reg.op == OP_WRITE) || (cmd_reg.op == OP_FILL);
                occ_wd = (cmd_reg.op == OP_FILL) ? 1'b1 : cmd_reg.wv;
                inf_we = (cmd_reg.op == OP_INFL);
            end
            default:
            begin
            end
        endcase
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pz_next    = pz_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        sz_next    = sz_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dz_next    = dz_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        q_pop      = 1'b0;

        case (state_reg)
            ST_INIT, ST_CLR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    px_next  = q_cmd.x;
                    py_next  = q_cmd.y;
                    pz_next  = q_cmd.z;
                    res_next = 1'b0;
                    cnt_next = '0;
                    case (q_cmd.op)
                        OP_CLEAR:
                        begin
                            state_next = ST_CLR;
                        end
                        OP_WRITE:
                        begin
                            state_next = q_cmd.in_grid ? ST_ROW : ST_DONE;
                        end
                        OP_QUERY, OP_QINF:
                        begin
                            res_next   = !q_cmd.in_grid;
                            state_next = q_cmd.in_grid ? ST_ROW : ST_DONE;
                        end
                        OP_FILL:
                        begin
                            state_next = q_cmd.box_empty ? ST_DONE : ST_ROW;
                        end
                        OP_INFL:
                        begin
                            state_next = ST_ICLR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                case (cmd_reg.op)
                    OP_QUERY, OP_QINF:
                    begin
                        state_next = ST_RDW;
                    end
                    OP_FILL, OP_INFL:
                    begin
                        state_next = ST_STEP;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RDW:
            begin
                res_next   = (cmd_reg.op == OP_QINF) ? inf_rd_reg : occ_rd_reg;
                state_next = ST_DONE;
            end
            ST_STEP:
            begin
                if (cmd_reg.op == OP_FILL)
                begin
                    state_next = ST_ROW;
                    if (pz_reg != cmd_reg.hz)
                    begin
                        pz_next = pz_reg + 1'b1;
                    end
                    else
                    begin
                        pz_next = cmd_reg.z;
                        if (py_reg != cmd_reg.hy)
                        begin
                            py_next = py_reg + 1'b1;
                        end
                        else
                        begin
                            py_next = cmd_reg.y;
                            if (px_reg != cmd_reg.hx)
                            begin
                                px_next = px_reg + 1'b1;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                    end
                end
                else if (!ball_last)
                begin
                    state_next = ST_BALL;
                    if (dz_reg != n5)
                    begin
                        dz_next = dz_reg + 5'sd1;
                    end
                    else
                    begin
                        dz_next = -n5;
                        if (dy_reg != n5)
                        begin
                            dy_next = dy_reg + 5'sd1;
                        end
                        else
                        begin
                            dy_next = -n5;
                            dx_next = dx_reg + 5'sd1;
                        end
                    end
                end
                else
                begin
                    // Ball finished: move the scan to the next voxel.
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = scan_last ? ST_DONE : ST_SRD;
                    if (sz_reg != cfg.uz - 1'b1)
                    begin
                        sz_next = sz_reg + 1'b1;
                    end
                    else
                    begin
                        sz_next = '0;
                        if (sy_reg != cfg.uy - 1'b1)
                        begin
                            sy_next = sy_reg + 1'b1;
                        end
                        else
                        begin
                            sy_next = '0;
                            sx_next = sx_reg + 1'b1;
                        end
                    end
                end
            end
            ST_ICLR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    sx_next    = '0;
                    sy_next    = '0;
                    sz_next    = '0;
                    state_next = ST_SRD;
                end
            end
            ST_SRD:
            begin
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                // An empty voxel goes straight to the scan step through a
                // ball that is already at its last point.
                dx_next    = occ_rd_reg ? -n5 : n5;
                dy_next    = occ_rd_reg ? -n5 : n5;
                dz_next    = occ_rd_reg ? -n5 : n5;
                state_next = occ_rd_reg ? ST_BALL : ST_STEP;
            end
            ST_BALL:
            begin
                px_next    = CW'(tx);
                py_next    = CW'(ty);
                pz_next    = CW'(tz);
                state_next = cand_ok ? ST_ROW : ST_STEP;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
        pz_reg  <= pz_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        sz_reg  <= sz_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dz_reg  <= dz_next;
        res_reg <= res_next;
        if (out_load)
        begin
            out_bit_reg <= res_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign occupied_bit = out_bit_reg;

endmodule

`default_nettype wire

FILE: rtl/core/vog_checker.sv
// ----------------------------------------------------------------------------
// vog_checker: port-level checks of the occupancy grid engine
// Tracks requests in flight and watches the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module vog_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic occupied_bit,
    input wire logic cfg_ready
);

    logic [2:0] pending_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(occupied_bit))
        else $error("result changed while stalled");

    // No result appears without a request behind it.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without a pending request");

    // Queue, sequencer and output register bound the requests in flight.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("too many requests in flight");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind voxel_occupancy_grid_engine vog_checker u_vog_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .occupied_bit (occupied_bit),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire

FILE: sim/voxel_occupancy_grid_engine_tb.sv
// ----------------------------------------------------------------------------
// voxel_occupancy_grid_engine_tb: self-checking bench of the voxel grid engine
// Drives command requests and register writes, keeps its own copy of both
// voxel maps, and checks every occupancy answer in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_occupancy_grid_engine_tb;
    import vog_pkg::*;

    // The two opcodes that the block must ignore.
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int GRID_DIM = 32;
    localparam int CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
    // Longest quiet stretch is a full-grid inflation with radius 15 around a
    // couple of voxels; allow far more.
    localparam int QUIET_LIMIT = 1500000;

    // Expected answers wait here in request order.
    class occupancy_scoreboard;
        bit pending[$];
        int errors;
        int checked;

        function void note(bit b);
            pending = {pending, b};
        endfunction

        task report(input string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check(input bit got);
            bit want;
            if (pending.size() == 0)
            begin
                report($sformatf("answer %0b with no request outstanding", got));
            end
            else
            begin
                want = pending.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("occupied_bit got %0b expected %0b", got, want));
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        opcode;
    logic signed [7:0] ax, ay, az, bx, by_corner, bz;
    logic              write_value;
    logic              out_valid;
    logic              out_ready;
    logic              occupied_bit;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [5:0]        cfg_data;

    voxel_occupancy_grid_engine DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .ax(ax), .ay(ay), .az(az),
        .bx(bx), .by_corner(by_corner), .bz(bz), .write_value(write_value),
        .out_valid(out_valid), .out_ready(out_ready), .occupied_bit(occupied_bit),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    occupancy_scoreboard sb;

    // Shadow copy of the block: both maps and the clamped configuration.
    bit occ_shadow[CELLS];
    bit infl_shadow[CELLS];
    int ext_x, ext_y, ext_z, ball_r;

    int quiet_cycles;
    int requests_sent;
    int stall_tick;
    bit stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow model of the engine.
    // ------------------------------------------------------------------
    function automatic bit voxel_inside(int x, int y, int z);
        return x >= 0 && y >= 0 && z >= 0 && x < ext_x && y < ext_y && z < ext_z;
    endfunction

    // x-major linear address under the current extents; stale bits left by
    // an extent change are deliberately read through this new mapping.
    function automatic int voxel_addr(int x, int y, int z);
        return (x * ext_y + y) * ext_z + z;
    endfunction

    function automatic int clamp_extent(int v);
        if (v < 1)
            return 1;
        if (v > GRID_DIM)
            return GRID_DIM;
        return v;
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [5:0] val);
        case (idx)
            REG_SIZE_X: ext_x = clamp_extent(int'(val));
            REG_SIZE_Y: ext_y = clamp_extent(int'(val));
            REG_SIZE_Z: ext_z = clamp_extent(int'(val));
            REG_RADIUS: ball_r = int'(val[3:0]);
            default: ;
        endcase
    endfunction

    // Inflated map: every in-grid voxel within the Euclidean ball of any
    // occupied voxel. The whole inflated memory is cleared first.
    function automatic void rebuild_inflated();
        int x, y, z, dx, dy, dz, r2;
        r2 = ball_r * ball_r;
        foreach (infl_shadow[i])
            infl_shadow[i] = 1'b0;
        for (x = 0; x < ext_x; x++)
            for (y = 0; y < ext_y; y++)
                for (z = 0; z < ext_z; z++)
                    if (occ_shadow[voxel_addr(x, y, z)])
                        for (dx = -ball_r; dx <= ball_r; dx++)
                            for (dy = -ball_r; dy <= ball_r; dy++)
                                for (dz = -ball_r; dz <= ball_r; dz++)
                                    if (dx*dx + dy*dy + dz*dz <= r2 &&
                                        voxel_inside(x+dx, y+dy, z+dz))
                                        infl_shadow[voxel_addr(x+dx, y+dy, z+dz)] = 1'b1;
    endfunction

    // Applies one command to the shadow maps and returns its answer bit.
    function automatic bit occupancy_answer(logic [2:0] op, int a_x, int a_y, int a_z,
                                            int b_x, int b_y, int b_z, bit wv);
        int lx, ly, lz, hx, hy, hz, x, y, z;
        bit ans;
        ans = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                foreach (occ_shadow[i])
                    occ_shadow[i] = 1'b0;
            end
            OP_WRITE:
            begin
                if (voxel_inside(a_x, a_y, a_z))
                    occ_shadow[voxel_addr(a_x, a_y, a_z)] = wv;
            end
            OP_QUERY:
                ans = voxel_inside(a_x, a_y, a_z) ? occ_shadow[voxel_addr(a_x, a_y, a_z)] : 1'b1;
            OP_FILL:
            begin
                lx = a_x < 0 ? 0 : a_x;
                ly = a_y < 0 ? 0 : a_y;
                lz = a_z < 0 ? 0 : a_z;
                hx = b_x > ext_x - 1 ? ext_x - 1 : b_x;
                hy = b_y > ext_y - 1 ? ext_y - 1 : b_y;
                hz = b_z > ext_z - 1 ? ext_z - 1 : b_z;
                for (x = lx; x <= hx; x++)
                    for (y = ly; y <= hy; y++)
                        for (z = lz; z <= hz; z++)
                            occ_shadow[voxel_addr(x, y, z)] = 1'b1;
            end
            OP_INFL:
                rebuild_inflated();
            OP_QINF:
                ans = voxel_inside(a_x, a_y, a_z) ? infl_shadow[voxel_addr(a_x, a_y, a_z)] : 1'b1;
            default: ;
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------

    // Presents one request and holds it until accepted. Valid is left high
    // so that the next request can follow back to back.
    task automatic send_request(input logic [2:0] op, input int a_x, input int a_y,
                                input int a_z, input int b_x, input int b_y,
                                input int b_z, input bit wv);
        in_valid    <= 1'b1;
        opcode      <= op;
        ax          <= 8'(a_x);
        ay          <= 8'(a_y);
        az          <= 8'(a_z);
        bx          <= 8'(b_x);
        by_corner   <= 8'(b_y);
        bz          <= 8'(b_z);
        write_value <= wv;
        do
            @(posedge clk);
        while (!in_ready);
        // Fields are predicted as the block sees them: 8-bit signed values.
        sb.note(occupancy_answer(op, int'($signed(8'(a_x))), int'($signed(8'(a_y))),
                                 int'($signed(8'(a_z))), int'($signed(8'(b_x))),
                                 int'($signed(8'(b_y))), int'($signed(8'(b_z))), wv));
        requests_sent++;
    endtask

    task automatic sender_gap(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Leaves valid high so that writes can follow back to back; the caller
    // drops it after the last one.
    task automatic write_register(input logic [1:0] idx, input logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, val);
    endtask

    // Holds off until every answer is back, then lets the pipeline settle.
    task automatic drain_answers();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_grid(input int sx, input int sy, input int sz, input int r);
        drain_answers();
        write_register(REG_SIZE_X, 6'(sx));
        write_register(REG_SIZE_Y, 6'(sy));
        write_register(REG_SIZE_Z, 6'(sz));
        write_register(REG_RADIUS, 6'(r));
        cfg_valid <= 1'b0;
    endtask

    // Mostly around the grid in use, sometimes anywhere in the signed range.
    function automatic int pick_coord(int n);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 85)
            return $urandom_range(0, n);
        if (sel < 90)
            return -1;
        return int'($signed(8'($urandom_range(0, 255))));
    endfunction

    // A random mix; clearing and inflation each sweep the whole memory, so
    // they are kept rare.
    task automatic random_requests(input int count);
        int k, sel, burst, lo_x, lo_y, lo_z;
        burst = $urandom_range(1, 20);
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 999);
            lo_x = pick_coord(ext_x);
            lo_y = pick_coord(ext_y);
            lo_z = pick_coord(ext_z);
            if (sel < 3)
                send_request(OP_CLEAR, lo_x, lo_y, lo_z, 0, 0, 0, $urandom_range(0, 1));
            else if (sel < 7)
                send_request(OP_INFL, lo_x, lo_y, lo_z, 0, 0, 0, $urandom_range(0, 1));
            else if (sel < 350)
                send_request(OP_WRITE, lo_x, lo_y, lo_z, pick_coord(ext_x),
                             pick_coord(ext_y), pick_coord(ext_z),
                             $urandom_range(0, 9) < 7);
            else if (sel < 600)
                send_request(OP_QUERY, lo_x, lo_y, lo_z, 0, 0, 0, $urandom_range(0, 1));
            else if (sel < 700)
                send_request(OP_FILL, lo_x - $urandom_range(0, 2), lo_y, lo_z,
                             lo_x + $urandom_range(0, 2), pick_coord(ext_y),
                             lo_z + $urandom_range(0, 3), $urandom_range(0, 1));
            else if (sel < 960)
                send_request(OP_QINF, lo_x, lo_y, lo_z, 0, 0, 0, $urandom_range(0, 1));
            else
                send_request(sel[0] ? OP_SPARE_A : OP_SPARE_B, lo_x, lo_y, lo_z,
                             pick_coord(ext_x), pick_coord(ext_y), pick_coord(ext_z),
                             $urandom_range(0, 1));
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 3) != 0)
                    sender_gap($urandom_range(1, 5));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls at random in some stretches, always ready in others.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check(occupied_bit);
            stall_tick <= stall_tick + 1;
            if (stall_tick % 97 == 0)
                stall_mode <= $urandom_range(0, 1);
            out_ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    // Watchdog: a long stretch without any handshake means the block hung.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int p, wait_cycles;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_CLEAR;
        ax = '0; ay = '0; az = '0;
        bx = '0; by_corner = '0; bz = '0;
        write_value = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SIZE_X;
        cfg_data = '0;
        quiet_cycles = 0;
        requests_sent = 0;
        stall_tick = 0;
        stall_mode = 1'b0;
        ext_x = GRID_DIM;
        ext_y = GRID_DIM;
        ext_z = GRID_DIM;
        ball_r = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset geometry (32 cubed, radius zero).
        send_request(OP_WRITE, 0, 0, 0, 0, 0, 0, 1'b1);
        send_request(OP_WRITE, 31, 31, 31, 0, 0, 0, 1'b1);
        // Writes outside the grid must be dropped.
        send_request(OP_WRITE, -1, 0, 0, 0, 0, 0, 1'b1);
        send_request(OP_WRITE, 32, 127, -128, 0, 0, 0, 1'b1);
        send_request(OP_QUERY, 0, 0, 0, 0, 0, 0, 1'b0);
        send_request(OP_QUERY, 31, 31, 31, 0, 0, 0, 1'b0);
        send_request(OP_QUERY, 5, 5, 5, 0, 0, 0, 1'b0);
        // Out-of-bounds queries read as occupied.
        send_request(OP_QUERY, -128, 0, 0, 0, 0, 0, 1'b0);
        send_request(OP_QUERY, 0, 127, 0, 0, 0, 0, 1'b0);
        send_request(OP_WRITE, 31, 31, 31, 0, 0, 0, 1'b0);
        send_request(OP_QUERY, 31, 31, 31, 0, 0, 0, 1'b0);
        // Box with corners clamped on both sides, then an empty box.
        send_request(OP_FILL, -5, 30, -128, 1, 127, 0, 1'b0);
        send_request(OP_FILL, 10, 10, 10, 9, 20, 20, 1'b0);
        send_request(OP_QUERY, 1, 31, 0, 0, 0, 0, 1'b0);
        send_request(OP_QUERY, 10, 10, 10, 0, 0, 0, 1'b0);
        // Radius zero makes the inflated map a copy.
        send_request(OP_INFL, 0, 0, 0, 0, 0, 0, 1'b0);
        send_request(OP_QINF, 0, 31, 0, 0, 0, 0, 1'b0);
        send_request(OP_QINF, 2, 31, 0, 0, 0, 0, 1'b0);
        send_request(OP_SPARE_A, 1, 1, 1, 1, 1, 1, 1'b1);
        send_request(OP_SPARE_B, -1, -1, -1, -1, -1, -1, 1'b1);
        // Clearing wipes the occupancy map but keeps the inflated one.
        send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0);
        send_request(OP_QUERY, 0, 0, 0, 0, 0, 0, 1'b0);
        send_request(OP_QINF, 0, 0, 0, 0, 0, 0, 1'b0);

        // Largest radius on the full grid, around two occupied corners only.
        // The size writes of 63 clamp to the full extent.
        set_grid(63, 63, 63, 15);
        send_request(OP_WRITE, 0, 0, 0, 0, 0, 0, 1'b1);
        send_request(OP_WRITE, 31, 31, 31, 0, 0, 0, 1'b1);
        send_request(OP_INFL, 0, 0, 0, 0, 0, 0, 1'b0);
        send_request(OP_QINF, 15, 0, 0, 0, 0, 0, 1'b0);
        send_request(OP_QINF, 16, 0, 0, 0, 0, 0, 1'b0);
        send_request(OP_QINF, 9, 9, 9, 0, 0, 0, 1'b0);
        send_request(OP_QINF, 8, 8, 8, 0, 0, 0, 1'b0);
        send_request(OP_QINF, 22, 22, 22, 0, 0, 0, 1'b0);
        send_request(OP_QINF, 16, 16, 16, 0, 0, 0, 1'b0);

        // Smallest grid: sizes of zero clamp to one voxel.
        set_grid(0, 0, 0, 1);
        random_requests(150);

        // Random geometries, mostly tiny, plus a long thin one.
        for (p = 0; p < 6; p++)
        begin
            if (p == 5)
                set_grid(63, 1, 1, 2);
            else
                set_grid($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 4),
                         $urandom_range(0, 2));
            // Make sure each geometry sees at least one inflation to query.
            send_request(OP_FILL, 0, 0, 0, 0, 1, 0, 1'b0);
            send_request(OP_INFL, 0, 0, 0, 0, 0, 0, 1'b0);
            random_requests(p == 2 ? 150 : 280);
            // The sender stands back once until every answer is in.
            if (p == 2)
            begin
                drain_answers();
                random_requests(130);
            end
        end

        in_valid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);

        $display("Ran %0d requests over full, one-voxel and small grids, radius 0 to 15;",
                 requests_sent);
        $display("%0d answers checked, %0d mismatches, %0d still outstanding.",
                 sb.checked, sb.errors, sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/vog_pkg.sv
rtl/core/vog_queue.sv
rtl/core/vog_front.sv
rtl/core/vog_back.sv
rtl/core/voxel_occupancy_grid_engine.sv
rtl/core/vog_checker.sv
sim/voxel_occupancy_grid_engine_tb.sv
